// ===== rtl/core/multi_mode_line_encoder_top_assert.svh =====
// assertion macros for the line encoder top level
`ifndef MULTI_MODE_LINE_ENCODER_TOP_ASSERT_SVH
`define MULTI_MODE_LINE_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge
`define MMLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising clock edge
`define MMLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mmle_pkg.sv =====
// shared types and constants for the line encoder
package mmle_pkg;

    localparam int BURST_MAX = 8;
    localparam int IDX_W     = $clog2(BURST_MAX);
    localparam int CNT_W     = IDX_W + 1;
    localparam int Q_DEPTH   = 2;
    localparam int QA_W      = $clog2(Q_DEPTH);

    localparam logic [2:0] LC_NRZL  = 3'd0;
    localparam logic [2:0] LC_NRZI  = 3'd1;
    localparam logic [2:0] LC_MAN   = 3'd2;
    localparam logic [2:0] LC_DMAN  = 3'd3;
    localparam logic [2:0] LC_AMI   = 3'd4;
    localparam logic [2:0] LC_HDB3  = 3'd5;
    localparam logic [2:0] LC_B8ZS  = 3'd6;

    localparam logic signed [1:0] LEVEL_POS  = 2'sb01;
    localparam logic signed [1:0] LEVEL_NEG  = 2'sb11;
    localparam logic signed [1:0] LEVEL_ZERO = 2'sb00;

    typedef struct packed {
        logic signed [1:0] level;
        logic              viol;
    } sym_t;

    typedef struct packed {
        logic [CNT_W-1:0]            count;
        sym_t [BURST_MAX-1:0]        sym;
    } burst_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic signed [1:0] pol_level(input logic positive);
        return positive ? LEVEL_POS : LEVEL_NEG;
    endfunction

endpackage

// ===== rtl/core/mmle_front.sv =====
// front end: accepts bits, tracks stream state and builds symbol bursts
module mmle_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        line_code,
    input  logic              cfg_clear,
    input  logic              push,
    input  logic              data_bit,
    input  logic              end_of_stream,
    input  mmle_pkg::q_status_t q_stat,
    output logic              accept,
    output logic              q_push,
    output mmle_pkg::burst_t  burst
);
    import mmle_pkg::*;

    logic [2:0] held_reg, held_next;
    logic       last_pos_reg, last_pos_next;
    logic       odd_reg, odd_next;
    logic       nrzi_reg, nrzi_next;
    logic       half_reg, half_next;

    assign accept = push && !q_stat.full;
    assign q_push = accept && (burst.count != '0);

    always_comb
    begin
        logic [CNT_W-1:0] n;
        logic             h_pos;
        n             = '0;
        burst.sym     = '0;
        held_next     = held_reg;
        last_pos_next = last_pos_reg;
        odd_next      = odd_reg;
        nrzi_next     = nrzi_reg;
        half_next     = half_reg;
        h_pos         = half_reg ^ ~data_bit;

        case (line_code)
            LC_NRZI:
            begin
                nrzi_next = nrzi_reg ^ data_bit;
                burst.sym[0].level = pol_level(nrzi_next);
                n = CNT_W'(1);
            end
            LC_MAN:
            begin
                burst.sym[0].level = pol_level(data_bit);
                burst.sym[1].level = pol_level(!data_bit);
                n = CNT_W'(2);
            end
            LC_DMAN:
            begin
                burst.sym[0].level = pol_level(h_pos);
                burst.sym[1].level = pol_level(!h_pos);
                half_next = !h_pos;
                n = CNT_W'(2);
            end
            LC_AMI:
            begin
                if (data_bit)
                begin
                    burst.sym[0].level = pol_level(!last_pos_reg);
                    last_pos_next = !last_pos_reg;
                    odd_next      = !odd_reg;
                end
                n = CNT_W'(1);
            end
            LC_HDB3:
            begin
                if (data_bit)
                begin
                    burst.sym[held_reg].level = pol_level(!last_pos_reg);
                    last_pos_next = !last_pos_reg;
                    odd_next      = !odd_reg;
                    n             = CNT_W'(held_reg) + CNT_W'(1);
                    held_next     = '0;
                end
                else if (held_reg >= 3'd3)
                begin
                    held_next = '0;
                    if (odd_reg)
                    begin
                        burst.sym[3] = '{level: pol_level(last_pos_reg), viol: 1'b1};
                    end
                    else
                    begin
                        burst.sym[0] = '{level: pol_level(!last_pos_reg), viol: 1'b1};
                        burst.sym[3] = '{level: pol_level(!last_pos_reg), viol: 1'b1};
                        last_pos_next = !last_pos_reg;
                    end
                    odd_next = 1'b0;
                    n = CNT_W'(4);
                end
                else
                begin
                    held_next = held_reg + 3'd1;
                end
            end
            LC_B8ZS:
            begin
                if (data_bit)
                begin
                    burst.sym[held_reg].level = pol_level(!last_pos_reg);
                    last_pos_next = !last_pos_reg;
                    odd_next      = !odd_reg;
                    n             = CNT_W'(held_reg) + CNT_W'(1);
                    held_next     = '0;
                end
                else if (held_reg == 3'd7)
                begin
                    held_next = '0;
                    burst.sym[3] = '{level: pol_level(last_pos_reg), viol: 1'b1};
                    burst.sym[4] = '{level: pol_level(!last_pos_reg), viol: 1'b1};
                    burst.sym[6] = '{level: pol_level(!last_pos_reg), viol: 1'b1};
                    burst.sym[7] = '{level: pol_level(last_pos_reg), viol: 1'b1};
                    n = CNT_W'(8);
                end
                else
                begin
                    held_next = held_reg + 3'd1;
                end
            end
            default:
            begin
                burst.sym[0].level = pol_level(data_bit);
                n = CNT_W'(1);
            end
        endcase

        // held zeros flushed as plain zero symbols after the burst
        if (end_of_stream)
        begin
            n             = n + CNT_W'(held_next);
            held_next     = '0;
            last_pos_next = 1'b0;
            odd_next      = 1'b0;
            nrzi_next     = 1'b0;
            half_next     = 1'b1;
        end
        burst.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            last_pos_reg <= 1'b0;
            odd_reg      <= 1'b0;
            nrzi_reg     <= 1'b0;
            half_reg     <= 1'b1;
        end
        else if (cfg_clear)
        begin
            held_reg     <= '0;
            last_pos_reg <= 1'b0;
            odd_reg      <= 1'b0;
            nrzi_reg     <= 1'b0;
            half_reg     <= 1'b1;
        end
        else if (accept)
        begin
            held_reg     <= held_next;
            last_pos_reg <= last_pos_next;
            odd_reg      <= odd_next;
            nrzi_reg     <= nrzi_next;
            half_reg     <= half_next;
        end
    end

endmodule

// ===== rtl/core/mmle_queue.sv =====
// short burst queue between front end and serializer
module mmle_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_push,
    input  mmle_pkg::burst_t    wr_burst,
    input  logic                q_pop,
    output mmle_pkg::burst_t    rd_burst,
    output mmle_pkg::q_status_t q_stat
);
    import mmle_pkg::*;

    burst_t            entry_reg [Q_DEPTH];
    logic [QA_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QA_W:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == (QA_W+1)'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = q_push && !q_stat.full;
    assign do_pop       = q_pop && !q_stat.empty;
    assign rd_burst     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QA_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QA_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QA_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QA_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_burst;
        end
    end

endmodule

// ===== rtl/core/mmle_back.sv =====
// back end: serializes bursts into one symbol per cycle while pop is held
module mmle_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  mmle_pkg::burst_t    rd_burst,
    input  mmle_pkg::q_status_t q_stat,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic signed [1:0]   level,
    output logic                violation,
    output logic                run_last
);
    import mmle_pkg::*;

    logic [IDX_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic signed [1:0] level_reg;
    logic              viol_reg;
    logic              last_reg;
    logic              load;
    logic              is_last;

    assign empty     = !out_valid_reg;
    assign level     = level_reg;
    assign violation = viol_reg;
    assign run_last  = last_reg;

    assign load    = !q_stat.empty && (!out_valid_reg || pop);
    assign is_last = ({1'b0, idx_reg} == rd_burst.count - CNT_W'(1));
    assign q_pop   = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? '0 : idx_reg + IDX_W'(1);
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg <= rd_burst.sym[idx_reg].level;
            viol_reg  <= rd_burst.sym[idx_reg].viol;
            last_reg  <= is_last;
        end
    end

endmodule

// ===== rtl/core/multi_mode_line_encoder_top.sv =====
// top level of the multi-mode line encoder
//
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------------
//  input     | push / full         | data_bit, end_of_stream
//  result    | pop / empty         | level, violation, run_last
//  config    | psel/penable/pwrite | paddr, pwdata, prdata (line_code)
//
// the front end takes one bit per cycle while the burst queue has room
// each bit yields zero to eight symbols, sent out at one symbol per cycle while pop is held
// so NRZ and AMI send one symbol per bit, Manchester codes two
// the serializer output register limits throughput; reset is async, active low
// a stalled result holds while the front end keeps filling the queue
module multi_mode_line_encoder_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              data_bit,
    input  logic              end_of_stream,
    output logic              empty,
    input  logic              pop,
    output logic signed [1:0] level,
    output logic              violation,
    output logic              run_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import mmle_pkg::*;

    `include "multi_mode_line_encoder_top_assert.svh"

    logic [2:0] line_code_reg;
    logic       cfg_wr;
    logic       accept;
    logic       q_push;
    logic       q_pop;
    burst_t     wr_burst;
    burst_t     rd_burst;
    q_status_t  q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, line_code_reg} : 32'd0;
    assign full   = q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_code_reg <= LC_NRZL;
        end
        else if (cfg_wr)
        begin
            line_code_reg <= pwdata[2:0];
        end
    end

    mmle_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .line_code     (line_code_reg),
        .cfg_clear     (cfg_wr),
        .push          (push),
        .data_bit      (data_bit),
        .end_of_stream (end_of_stream),
        .q_stat        (q_stat),
        .accept        (accept),
        .q_push        (q_push),
        .burst         (wr_burst)
    );

    mmle_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .wr_burst (wr_burst),
        .q_pop    (q_pop),
        .rd_burst (rd_burst),
        .q_stat   (q_stat)
    );

    mmle_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_burst  (rd_burst),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .level     (level),
        .violation (violation),
        .run_last  (run_last)
    );

    `MMLE_ASSERT_NOW(a_level_legal, !empty, level != 2'sb10, "illegal line level")
    `MMLE_ASSERT_NOW(a_viol_pulse, !empty && violation, level != LEVEL_ZERO, "zero-level violation")
    `MMLE_ASSERT_NOW(a_push_nonempty, q_push, wr_burst.count != '0, "empty burst queued")
    `MMLE_ASSERT_NEXT(a_pop_refill, q_pop && !q_push && !q_stat.full, !q_stat.full, "queue full after pop")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for multi_mode_line_encoder_top
module testbench;
    import mmle_pkg::*;

    localparam logic [2:0] LC_SPARE       = 3'd7;
    localparam logic [2:0] ADDR_LINE_CODE = 3'd0;
    localparam logic [2:0] ADDR_NO_REG    = 3'd4;
    localparam int         TYPED_NONE     = -1;
    localparam int         SETTLE_CYCLES  = 24;
    localparam int         N_PHASES       = 16;
    localparam int         N_DIRECTED     = 25;
    localparam int         PRINT_CAP      = 40;

    typedef struct packed {
        logic signed [1:0] level;
        logic              viol;
        logic              last_of_run;
    } line_sym_t;

    typedef struct packed {
        logic [2:0]        code;
        logic              din;
        logic              eos;
        int                n;
        logic signed [1:0] lv_a;
        logic signed [1:0] lv_b;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              data_bit;
    logic              end_of_stream;
    logic              empty;
    logic              pop;
    logic signed [1:0] level;
    logic              violation;
    logic              run_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // encoder model state
    logic [2:0] cur_code;
    int         held_zeros;
    logic       last_pos;
    logic       parity_odd;
    logic       nrzi_pos;
    logic       half_pos;

    line_sym_t  pending_symbols[$];
    line_sym_t  burst[$];
    line_sym_t  want;
    int         mismatches = 0;
    bit         quiet_tail = 1'b0;

    stim_row_t  directed_rows [N_DIRECTED];
    logic [2:0] phase_codes [N_PHASES];

    multi_mode_line_encoder_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_bit      (data_bit),
        .end_of_stream (end_of_stream),
        .empty         (empty),
        .pop           (pop),
        .level         (level),
        .violation     (violation),
        .run_last      (run_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #4 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic clear_stream();
        held_zeros = 0;
        last_pos   = 1'b0;
        parity_odd = 1'b0;
        nrzi_pos   = 1'b0;
        half_pos   = 1'b1;
    endtask

    task automatic queue_expected(input line_sym_t s);
        pending_symbols.insert(pending_symbols.size(), s);
    endtask

    task automatic put_sym(input logic signed [1:0] lv, input logic viol);
        line_sym_t s;
        s = '{lv, viol, 1'b0};
        burst.insert(burst.size(), s);
    endtask

    task automatic put_pulse(input logic positive, input logic viol);
        put_sym(positive ? LEVEL_POS : LEVEL_NEG, viol);
    endtask

    task automatic put_mark();
        put_pulse(!last_pos, 1'b0);
        last_pos   = !last_pos;
        parity_odd = !parity_odd;
    endtask

    task automatic release_zeros();
        while (held_zeros > 0)
        begin
            put_sym(LEVEL_ZERO, 1'b0);
            held_zeros--;
        end
    endtask

    // symbols caused by one data bit, left in burst
    task automatic encode_bit(input logic din, input logic eos);
        logic h;
        logic p;
        burst.delete();
        case (cur_code)
            LC_NRZI:
            begin
                if (din)
                    nrzi_pos = !nrzi_pos;
                put_pulse(nrzi_pos, 1'b0);
            end
            LC_MAN:
            begin
                put_pulse(din, 1'b0);
                put_pulse(!din, 1'b0);
            end
            LC_DMAN:
            begin
                h = din ? half_pos : !half_pos;
                put_pulse(h, 1'b0);
                put_pulse(!h, 1'b0);
                half_pos = !h;
            end
            LC_AMI:
            begin
                if (din)
                    put_mark();
                else
                    put_sym(LEVEL_ZERO, 1'b0);
            end
            LC_HDB3:
            begin
                if (din)
                begin
                    release_zeros();
                    put_mark();
                end
                else if (held_zeros >= 3)
                begin
                    held_zeros = 0;
                    p = last_pos;
                    if (parity_odd)
                    begin
                        // 000V
                        put_sym(LEVEL_ZERO, 1'b0);
                        put_sym(LEVEL_ZERO, 1'b0);
                        put_sym(LEVEL_ZERO, 1'b0);
                        put_pulse(p, 1'b1);
                    end
                    else
                    begin
                        // B00V
                        put_pulse(!p, 1'b1);
                        put_sym(LEVEL_ZERO, 1'b0);
                        put_sym(LEVEL_ZERO, 1'b0);
                        put_pulse(!p, 1'b1);
                        last_pos = !p;
                    end
                    parity_odd = 1'b0;
                end
                else
                    held_zeros++;
            end
            LC_B8ZS:
            begin
                if (din)
                begin
                    release_zeros();
                    put_mark();
                end
                else if (held_zeros >= 7)
                begin
                    // 000VB0VB
                    held_zeros = 0;
                    p = last_pos;
                    put_sym(LEVEL_ZERO, 1'b0);
                    put_sym(LEVEL_ZERO, 1'b0);
                    put_sym(LEVEL_ZERO, 1'b0);
                    put_pulse(p, 1'b1);
                    put_pulse(!p, 1'b1);
                    put_sym(LEVEL_ZERO, 1'b0);
                    put_pulse(!p, 1'b1);
                    put_pulse(p, 1'b1);
                end
                else
                    held_zeros++;
            end
            default:
                put_pulse(din, 1'b0);
        endcase
        if (eos)
        begin
            release_zeros();
            clear_stream();
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LINE_CODE)
        begin
            cur_code = data[2:0];
            clear_stream();
        end
    endtask

    // drain, let held-zero transactions settle, then reprogram
    task automatic switch_code(input logic [2:0] code);
        logic [31:0] noise;
        noise = $urandom;
        push <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if ($urandom_range(0, 2) == 0)
            apb_write(ADDR_NO_REG, $urandom);
        apb_write(ADDR_LINE_CODE, {noise[31:3], code});
    endtask

    task automatic send_bit(input logic din, input logic eos, input logic use_model);
        push          <= 1'b1;
        data_bit      <= din;
        end_of_stream <= eos;
        @(posedge clk);
        while (full)
            @(posedge clk);
        encode_bit(din, eos);
        if (use_model)
            foreach (burst[k])
                queue_expected(burst[k]);
    endtask

    function automatic stim_row_t stim(input logic [2:0] code, input logic din,
                                       input logic eos, input int n,
                                       input logic signed [1:0] a,
                                       input logic signed [1:0] b);
        stim_row_t r;
        r.code = code;
        r.din  = din;
        r.eos  = eos;
        r.n    = n;
        r.lv_a = a;
        r.lv_b = b;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_symbols.size() == 0)
                flag_mismatch($sformatf("unexpected symbol level %0d viol %0b last %0b",
                                        level, violation, run_last));
            else
            begin
                want = pending_symbols.pop_front();
                if (level !== want.level || violation !== want.viol ||
                    run_last !== want.last_of_run)
                    flag_mismatch($sformatf("got level %0d viol %0b last %0b, want %0d %0b %0b",
                                            level, violation, run_last,
                                            want.level, want.viol, want.last_of_run));
            end
        end
    end

    // result side stalls in bursts
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    initial
    begin
        #5000000;
        $display("[multi_mode_line_encoder_top] ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t r;
        line_sym_t typed_sym;
        int        zero_run;
        logic      din;
        logic      eos;
        rst_n         <= 1'b0;
        push          <= 1'b0;
        data_bit      <= 1'b0;
        end_of_stream <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= ADDR_LINE_CODE;
        pwdata        <= 32'd0;
        cur_code = LC_NRZL;
        clear_stream();

        directed_rows = '{
            stim(LC_NRZL,  1'b1, 1'b0, 1,          LEVEL_POS,  LEVEL_ZERO),
            stim(LC_SPARE, 1'b0, 1'b0, 1,          LEVEL_NEG,  LEVEL_ZERO),
            stim(LC_SPARE, 1'b1, 1'b1, 1,          LEVEL_POS,  LEVEL_ZERO),
            stim(LC_NRZI,  1'b1, 1'b0, 1,          LEVEL_POS,  LEVEL_ZERO),
            stim(LC_MAN,   1'b1, 1'b0, 2,          LEVEL_POS,  LEVEL_NEG),
            stim(LC_MAN,   1'b0, 1'b1, 2,          LEVEL_NEG,  LEVEL_POS),
            stim(LC_DMAN,  1'b0, 1'b0, 2,          LEVEL_NEG,  LEVEL_POS),
            stim(LC_AMI,   1'b1, 1'b0, 1,          LEVEL_POS,  LEVEL_ZERO),
            stim(LC_AMI,   1'b0, 1'b0, 1,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_AMI,   1'b1, 1'b1, TYPED_NONE, LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_HDB3,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_HDB3,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_HDB3,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_HDB3,  1'b0, 1'b0, TYPED_NONE, LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_HDB3,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_HDB3,  1'b1, 1'b0, TYPED_NONE, LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_HDB3,  1'b0, 1'b1, 1,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_B8ZS,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_B8ZS,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_B8ZS,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_B8ZS,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_B8ZS,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_B8ZS,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_B8ZS,  1'b0, 1'b0, 0,          LEVEL_ZERO, LEVEL_ZERO),
            stim(LC_B8ZS,  1'b0, 1'b1, TYPED_NONE, LEVEL_ZERO, LEVEL_ZERO)
        };
        phase_codes = '{LC_HDB3, LC_B8ZS, LC_NRZL, LC_SPARE, LC_NRZI, LC_MAN,
                        LC_DMAN, LC_AMI, LC_B8ZS, LC_HDB3, LC_AMI, LC_DMAN,
                        LC_HDB3, LC_B8ZS, LC_MAN, LC_HDB3};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.code != cur_code)
                switch_code(r.code);
            send_bit(r.din, r.eos, r.n == TYPED_NONE);
            if (r.n > 0)
            begin
                typed_sym = '{r.lv_a, 1'b0, r.n == 1};
                queue_expected(typed_sym);
            end
            if (r.n > 1)
            begin
                typed_sym = '{r.lv_b, 1'b0, 1'b1};
                queue_expected(typed_sym);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            switch_code(phase_codes[ph]);
            if (ph >= N_PHASES - 2)
                quiet_tail = 1'b1;
            zero_run = 0;
            repeat ($urandom_range(14, 26))
            begin
                if (cur_code == LC_HDB3 || cur_code == LC_B8ZS)
                begin
                    // mostly runs of zeros long enough to substitute
                    if (zero_run > 0)
                    begin
                        din = 1'b0;
                        zero_run--;
                    end
                    else
                    begin
                        din = 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            zero_run = $urandom_range(0, 2);
                        else if (cur_code == LC_HDB3)
                            zero_run = $urandom_range(3, 9);
                        else
                            zero_run = $urandom_range(6, 18);
                    end
                end
                else
                    din = $urandom_range(0, 1);
                eos = ($urandom_range(0, 15) == 0);
                send_bit(din, eos, 1'b1);
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                begin
                    push <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge clk);
                end
            end
        end

        push <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[multi_mode_line_encoder_top] OK");
        else
            $display("[multi_mode_line_encoder_top] ERROR");
        $finish;
    end

endmodule
